// ===== hw/rtl/etm_pkg.sv =====
// Shared widths, register indexes and pipeline tag type for the embedding
// threshold match block. No dependencies.
`timescale 1ns / 1ps

package etm_pkg;

  localparam int ElemW    = 16;
  localparam int EntryW   = 8;
  localparam int ElemIdxW = 7;
  localparam int DistW    = 39;
  localparam int EntriesW = 9;
  localparam int CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] RegThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEntries   = 2'd1;

  localparam logic [DistW-1:0] ThresholdReset = 39'd247390116;
  localparam logic [DistW-1:0] DistMax        = {DistW{1'b1}};

  localparam logic FuncGallery = 1'b0;
  localparam logic FuncQuery   = 1'b1;

  typedef struct packed {
    logic              last_elem;
    logic              last_entry;
    logic [EntryW-1:0] entry;
  } tag_t;

endpackage

// ===== hw/rtl/etm_if.sv =====
// Request and result channel interfaces of the embedding threshold match block.
// Depends on etm_pkg.
`timescale 1ns / 1ps

interface etm_item_if import etm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [EntryW-1:0]       entry_index;
  logic [ElemIdxW-1:0]     element_index;
  logic signed [ElemW-1:0] element_value;
  logic                    end_of_query;

  modport source (output valid, func, entry_index, element_index, element_value,
                  end_of_query, input ready);
  modport sink (input valid, func, entry_index, element_index, element_value,
                end_of_query, output ready);
endinterface

interface etm_result_if import etm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              matched;
  logic [EntryW-1:0] match_index;
  logic [DistW-1:0]  match_distance_sq;

  modport source (output valid, matched, match_index, match_distance_sq, input ready);
  modport sink (input valid, matched, match_index, match_distance_sq, output ready);
endinterface

// ===== hw/rtl/embedding_threshold_match.sv =====
// Top level of the embedding threshold match block: gallery and query memories,
// the distance pipeline and the search control. Depends on etm_pkg and etm_if.
`timescale 1ns / 1ps

// Each request writes one gallery or query element, and the last query
// element also starts a search. A search reads one element pair per cycle
// through the single read port of the gallery memory and ends early at the
// first entry whose squared distance is below threshold_squared. No request
// is taken during a search. Gallery and query contents are undefined until
// written; a search must only touch written elements. Registers may be
// written only while the block is idle.
module embedding_threshold_match import etm_pkg::*; #(
  parameter int VECTOR_LEN    = 128,
  parameter int GALLERY_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [DistW-1:0]   wr_data,
  etm_item_if.sink           item,
  etm_result_if.source       result
);

  localparam int ElemAddrW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
  localparam int GalAddrW  = (GALLERY_DEPTH * VECTOR_LEN > 1) ?
                             $clog2(GALLERY_DEPTH * VECTOR_LEN) : 1;
  localparam int EntryIdxW = (GALLERY_DEPTH > 1) ? $clog2(GALLERY_DEPTH) : 1;
  localparam int AccW      = DistW + 1;
  localparam int SqW       = 2 * ElemW;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [DistW-1:0]    threshold_squared;
  logic [EntriesW-1:0] entries_in_use;

  logic [1:0]           state;
  logic                 issuing;
  logic [GalAddrW-1:0]  ga;
  logic [ElemAddrW-1:0] ie;
  logic [EntryIdxW-1:0] ik;
  logic [EntryIdxW-1:0] last_k;

  logic                    v1, v2, v3, v4;
  tag_t                    t1, t2, t3, t4;
  logic signed [ElemW-1:0] gal_rd, qry_rd;
  logic [ElemW:0]          diff;
  logic [SqW-1:0]          sq;
  logic [DistW-1:0]        acc;
  logic [DistW-1:0]        entry_dist;

  logic              res_matched;
  logic [EntryW-1:0] res_index;
  logic [DistW-1:0]  res_dist;

  logic              rsp_valid;
  logic              rsp_matched;
  logic [EntryW-1:0] rsp_index;
  logic [DistW-1:0]  rsp_dist;

  logic signed [ElemW-1:0] gal_mem [GALLERY_DEPTH * VECTOR_LEN];
  logic signed [ElemW-1:0] qry_mem [VECTOR_LEN];

  logic                 accept, start, empty, issue, load, hit;
  logic                 entry_ok, elem_ok, gal_we, qry_we;
  logic [GalAddrW-1:0]  gal_waddr;
  logic [ElemAddrW-1:0] elem_addr;
  int                   cnt;
  logic [ElemW:0]       mag;
  logic [ElemW-1:0]     mag_lo;
  logic [AccW-1:0]      sum;
  logic [DistW-1:0]     sum_sat;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign entry_ok   = int'(item.entry_index) < GALLERY_DEPTH;
  assign elem_ok    = int'(item.element_index) < VECTOR_LEN;
  assign elem_addr  = ElemAddrW'(item.element_index);
  assign gal_waddr  = GalAddrW'(int'(item.entry_index) * VECTOR_LEN +
                                int'(item.element_index));
  assign gal_we     = accept && (item.func == FuncGallery) && entry_ok && elem_ok;
  assign qry_we     = accept && (item.func == FuncQuery) && elem_ok;
  assign start      = accept && (item.func == FuncQuery) && item.end_of_query;
  assign cnt        = (int'(entries_in_use) > GALLERY_DEPTH) ? GALLERY_DEPTH :
                      int'(entries_in_use);
  assign empty      = (cnt == 0);
  assign issue      = (state == S_SEARCH) && issuing;

  assign mag     = diff[ElemW] ? (~diff + 1'b1) : diff;
  assign mag_lo  = mag[ElemW-1:0];
  assign sum     = AccW'(acc) + AccW'(sq);
  assign sum_sat = (sum > AccW'(DistMax)) ? DistMax : sum[DistW-1:0];
  assign hit     = entry_dist < threshold_squared;
  assign load    = (state == S_FINISH) && (!rsp_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_squared <= ThresholdReset;
      entries_in_use    <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        RegThreshold: threshold_squared <= wr_data;
        RegEntries:   entries_in_use    <= wr_data[EntriesW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (gal_we) begin
      gal_mem[gal_waddr] <= item.element_value;
    end
    if (issue) begin
      gal_rd <= gal_mem[ga];
    end
  end

  always_ff @(posedge clk) begin
    if (qry_we) begin
      qry_mem[elem_addr] <= item.element_value;
    end
    if (issue) begin
      qry_rd <= qry_mem[ie];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || state != S_SEARCH) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3 && t3.last_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      t1.last_elem  <= (ie == ElemAddrW'(VECTOR_LEN - 1));
      t1.last_entry <= (ik == last_k);
      t1.entry      <= EntryW'(ik);
    end
    t2   <= t1;
    t3   <= t2;
    diff <= {qry_rd[ElemW-1], qry_rd} - {gal_rd[ElemW-1], gal_rd};
    sq   <= mag_lo * mag_lo;
    if (start) begin
      acc <= '0;
    end else if (v3) begin
      if (t3.last_elem) begin
        acc        <= '0;
        entry_dist <= sum_sat;
        t4         <= t3;
      end else begin
        acc <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      issuing <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            res_matched <= 1'b0;
            res_index   <= '0;
            res_dist    <= '0;
            ga          <= '0;
            ie          <= '0;
            ik          <= '0;
            last_k      <= EntryIdxW'(cnt - 1);
            issuing     <= !empty;
            state       <= empty ? S_FINISH : S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (issue) begin
            ga <= ga + 1'b1;
            if (ie == ElemAddrW'(VECTOR_LEN - 1)) begin
              ie <= '0;
              ik <= ik + 1'b1;
              if (ik == last_k) begin
                issuing <= 1'b0;
              end
            end else begin
              ie <= ie + 1'b1;
            end
          end
          if (v4 && (hit || t4.last_entry)) begin
            res_matched <= hit;
            res_index   <= hit ? t4.entry : '0;
            res_dist    <= hit ? entry_dist : '0;
            issuing     <= 1'b0;
            state       <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (result.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_matched <= res_matched;
      rsp_index   <= res_index;
      rsp_dist    <= res_dist;
    end
  end

  assign result.valid             = rsp_valid;
  assign result.matched           = rsp_matched;
  assign result.match_index       = rsp_index;
  assign result.match_distance_sq = rsp_dist;

  a_match_below_threshold: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.matched |-> result.match_distance_sq < threshold_squared)
    else $error("reported match is not below the threshold");

  a_no_match_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.matched |->
      result.match_index == '0 && result.match_distance_sq == '0)
    else $error("no-match result carries a nonzero index or distance");

  a_search_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_SEARCH) |-> $past(start))
    else $error("search began without a final query element");

endmodule

// ===== sim/etm_match_checker.sv =====
// Scoreboard for the embedding threshold match block: mirrors register, gallery and
// query writes, predicts the outcome of each search and checks every result.
// Depends on etm_pkg and the request and result interfaces in etm_if.
`timescale 1ns / 1ps

module etm_match_checker import etm_pkg::*; #(
  parameter int VECTOR_LEN    = 128,
  parameter int GALLERY_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [DistW-1:0]   wr_data,
  etm_item_if                req,
  etm_result_if              res,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic              matched;
    logic [EntryW-1:0] index;
    logic [DistW-1:0]  distance;
  } search_result_t;

  logic signed [ElemW-1:0] gallery_mirror [GALLERY_DEPTH][VECTOR_LEN];
  logic signed [ElemW-1:0] query_mirror [VECTOR_LEN];
  logic [DistW-1:0]        threshold_sq;
  logic [EntriesW-1:0]     entry_count;
  search_result_t          expected_matches[$];
  search_result_t          oldest;

  function automatic search_result_t find_first_match();
    search_result_t found;
    longint sum_sq;
    longint diff;
    int searched;
    found = '0;
    searched = (entry_count > EntriesW'(GALLERY_DEPTH)) ? GALLERY_DEPTH : int'(entry_count);
    for (int k = 0; k < searched; k++) begin
      sum_sq = 0;
      for (int e = 0; e < VECTOR_LEN; e++) begin
        diff = longint'(query_mirror[e]) - longint'(gallery_mirror[k][e]);
        sum_sq += diff * diff;
      end
      if (sum_sq > longint'(DistMax)) sum_sq = longint'(DistMax);
      if (sum_sq < longint'(threshold_sq)) begin
        found.matched  = 1'b1;
        found.index    = EntryW'(k);
        found.distance = DistW'(sum_sq);
        return found;
      end
    end
    return found;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      threshold_sq = ThresholdReset;
      entry_count  = '0;
      errors       = 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          RegThreshold: threshold_sq = wr_data;
          RegEntries:   entry_count  = wr_data[EntriesW-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (req.func == FuncGallery) begin
          gallery_mirror[req.entry_index][req.element_index] = req.element_value;
        end else begin
          query_mirror[req.element_index] = req.element_value;
          if (req.end_of_query) expected_matches = {expected_matches, find_first_match()};
        end
      end
      if (res.valid && res.ready) begin
        if (expected_matches.size() == 0) begin
          $display("%0t: expected no result, got matched %0b index %0d distance %0d",
                   $time, res.matched, res.match_index, res.match_distance_sq);
          errors++;
        end else begin
          oldest = expected_matches.pop_front();
          compare_field("matched", 64'(oldest.matched), 64'(res.matched));
          compare_field("match_index", 64'(oldest.index), 64'(res.match_index));
          compare_field("match_distance_sq", 64'(oldest.distance),
                        64'(res.match_distance_sq));
        end
      end
    end
    pending = expected_matches.size();
  end

endmodule

// ===== sim/tb.sv =====
// Top of the embedding threshold match testbench: clock, reset, register writes,
// request stimulus, result back-pressure and the verdict.
// Depends on etm_pkg, etm_if, etm_match_checker and embedding_threshold_match.
`timescale 1ns / 1ps

module tb;
  import etm_pkg::*;

  localparam int VecLen        = 128;
  localparam int FilledEntries = 4;
  localparam int SearchLimit   = FilledEntries - 1;
  localparam int LongHold      = 3000;
  localparam int RandomPhases  = 8;
  localparam int PhaseRequests = 65;

  localparam logic [CfgIdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 2'd3;

  localparam logic signed [ElemW-1:0] ElemMin = 16'sh8000;
  localparam logic signed [ElemW-1:0] ElemMax = 16'sh7fff;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               wr_en    = 1'b0;
  logic [CfgIdxW-1:0] wr_index = '0;
  logic [DistW-1:0]   wr_data  = '0;

  int errors;
  int pending;
  bit no_idle    = 1'b0;
  bit long_hold  = 1'b0;
  int stall_left = 0;

  logic signed [ElemW-1:0] query_vals [VecLen];

  etm_item_if   item_ch ();
  etm_result_if result_ch ();

  embedding_threshold_match dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .item     (item_ch),
    .result   (result_ch)
  );

  etm_match_checker match_check (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (item_ch),
    .res      (result_ch),
    .errors   (errors),
    .pending  (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic signed [ElemW-1:0] near_value();
    int v;
    v = int'($urandom_range(0, 511)) - 256;
    return v[ElemW-1:0];
  endfunction

  function automatic logic signed [ElemW-1:0] any_value();
    logic [31:0] r;
    r = $urandom;
    return r[ElemW-1:0];
  endfunction

  task automatic send_req(input logic func, input logic [EntryW-1:0] ent,
                          input logic [ElemIdxW-1:0] el, input logic signed [ElemW-1:0] value,
                          input logic last);
    int gap;
    gap = (no_idle || $urandom_range(0, 2) != 0) ? 0 : gap_cycles();
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.func          <= func;
    item_ch.entry_index   <= ent;
    item_ch.element_index <= el;
    item_ch.element_value <= value;
    item_ch.end_of_query  <= last;
    if (func == FuncQuery) query_vals[el] = value;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DistW-1:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic configure(input logic [DistW-1:0] thr, input logic [DistW-1:0] count_word);
    drain();
    write_reg(RegThreshold, thr);
    write_reg(RegEntries, count_word);
  endtask

  // The result side stalls at random, and once for a long stretch on request.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = LongHold;
      end else if (stall_left == 0 && !no_idle && $urandom_range(0, 3) == 0) begin
        stall_left = gap_cycles();
      end
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic signed [ElemW-1:0] saved;
    logic [DistW-1:0] thr;
    logic [DistW-1:0] count_word;
    int count;
    int r;
    item_ch.valid         <= 1'b0;
    item_ch.func          <= FuncGallery;
    item_ch.entry_index   <= '0;
    item_ch.element_index <= '0;
    item_ch.element_value <= '0;
    item_ch.end_of_query  <= 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A search with no enrolled entries, and a gallery request whose end flag is ignored.
    send_req(FuncQuery, '0, '0, ElemMin, 1'b1);
    send_req(FuncGallery, EntryW'(255), ElemIdxW'(127), ElemMax, 1'b1);

    // Every searched element is written before any search reads it. Entry 2 is a copy of
    // the query, and one entry past the searched ones is filled as well.
    for (int e = 0; e < VecLen; e++)
      send_req(FuncQuery, EntryW'($urandom), ElemIdxW'(e), near_value(), 1'b0);
    for (int k = 0; k < FilledEntries; k++)
      for (int e = 0; e < VecLen; e++)
        send_req(FuncGallery, EntryW'(k), ElemIdxW'(e),
                 (k == 2) ? query_vals[e] : near_value(), 1'($urandom));

    // A distance of zero misses a zero threshold and hits a threshold of one.
    configure('0, DistW'(SearchLimit));
    send_req(FuncQuery, '0, ElemIdxW'(127), query_vals[127], 1'b1);
    configure(DistW'(1), DistW'(SearchLimit));
    send_req(FuncQuery, '0, ElemIdxW'(127), query_vals[127], 1'b1);

    // A distance equal to the threshold is not a match.
    saved = query_vals[5];
    configure(DistW'(9), DistW'(SearchLimit));
    send_req(FuncQuery, '0, ElemIdxW'(5), saved + 16'sd3, 1'b1);
    configure(DistW'(10), DistW'(SearchLimit));
    send_req(FuncQuery, '0, ElemIdxW'(5), saved + 16'sd3, 1'b1);
    send_req(FuncQuery, '0, ElemIdxW'(5), saved, 1'b0);

    // Full gallery count and a count above the gallery size; entry 0 always matches.
    saved = query_vals[127];
    configure(DistMax, DistW'(256));
    send_req(FuncQuery, '0, ElemIdxW'(127), ElemMax, 1'b1);
    send_req(FuncQuery, '0, ElemIdxW'(127), ElemMin, 1'b1);
    send_req(FuncQuery, '0, ElemIdxW'(127), saved, 1'b0);
    send_req(FuncGallery, EntryW'(255), '0, ElemMin, 1'b1);
    configure(DistMax, DistW'(511));
    send_req(FuncQuery, '0, '0, query_vals[0], 1'b1);

    // Writes to unused register indexes leave the setting unchanged.
    drain();
    write_reg(RegSpareLo, '0);
    write_reg(RegSpareHi, DistMax);
    send_req(FuncQuery, '0, '0, query_vals[0], 1'b1);
    configure(ThresholdReset, DistW'(SearchLimit));
    send_req(FuncQuery, EntryW'(255), ElemIdxW'(64), query_vals[64], 1'b1);

    for (int phase = 0; phase < RandomPhases; phase++) begin
      r = $urandom_range(0, 9);
      case (r)
        0, 1, 2, 3: thr = DistW'($urandom_range(0, 1 << 24));
        4, 5:       thr = DistW'({$urandom, $urandom});
        6:          thr = '0;
        7:          thr = DistMax;
        8:          thr = ThresholdReset;
        default:    thr = DistW'($urandom);
      endcase
      if (thr == DistMax && $urandom_range(0, 1) == 1) count = $urandom_range(0, 511);
      else count = $urandom_range(0, SearchLimit);
      count_word = DistW'({$urandom, $urandom});
      count_word[EntriesW-1:0] = EntriesW'(count);
      configure(thr, count_word);
      no_idle = (phase % 3 == 2);
      if (phase == 1) long_hold = 1'b1;
      for (int n = 0; n < PhaseRequests; n++) begin
        r = $urandom_range(0, 99);
        if (r < 70)
          send_req(FuncQuery, EntryW'($urandom), ElemIdxW'($urandom),
                   ($urandom_range(0, 19) == 0) ? any_value() : near_value(),
                   $urandom_range(0, 3) == 0);
        else if (r < 85)
          send_req(FuncGallery, EntryW'($urandom_range(0, FilledEntries - 1)),
                   ElemIdxW'($urandom), near_value(), 1'($urandom));
        else
          send_req(FuncGallery, EntryW'($urandom), ElemIdxW'($urandom), any_value(),
                   1'($urandom));
      end
    end

    drain();
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
